// ===== rtl/dqe_pkg.sv =====
// Shared types and constants for the double-ended queue engine.
`default_nettype none

package dqe_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int WORD_W    = 32;
	localparam int KIND_W    = 3;
	localparam int COUNT_W   = 5;
	localparam int STATUS_W  = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_PUT_FRONT  = 3'd0,
		KIND_PUT_BACK   = 3'd1,
		KIND_TAKE_FRONT = 3'd2,
		KIND_TAKE_BACK  = 3'd3,
		KIND_CLEAR      = 3'd4,
		KIND_SORT       = 3'd5,
		KIND_DEDUPE     = 3'd6,
		KIND_REVERSE    = 3'd7
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_POP,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_SORT_TAIL,
		ST_REV_RA,
		ST_REV_RB,
		ST_REV_W1,
		ST_REV_W2
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/dqe_store.sv =====
// Word storage of the deque: one write port and one registered read port.
`default_nettype none

module dqe_store #(
	parameter int DEPTH = dqe_pkg::DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic                            clk,
	input  wire logic                            we,
	input  wire logic [AW-1:0]                   waddr,
	input  wire logic signed [dqe_pkg::WORD_W-1:0] wdata,
	input  wire logic [AW-1:0]                   raddr,
	output logic signed [dqe_pkg::WORD_W-1:0]    rdata
);

	logic signed [dqe_pkg::WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/double_ended_queue_engine.sv =====
// Top level of the double-ended queue engine: request sequencer and ring control.
//
// A request is taken when start is high and busy is low: kind selects the
// operation and value carries the word for a push. Exactly one result follows
// per request, shown for one cycle while done is high, with removed_value,
// count and status. The result ports cannot be held off by the receiver.
//
// Steps by request kind:
//   push, clear, refused request, or sort/dedupe/reverse of under two words:
//     answered from idle, and busy stays low, so one of these requests can be taken per cycle.
//   pop: the read is issued on acceptance and the word is taken in ST_POP.
//   dedupe: each word is read and compared with the last kept word, one at a time.
//   reverse: each pair of words from the two ends is read and written back swapped.
//   sort: bubble passes, each stepping through every word and ending with a tail write,
//     with between one and n passes for n words.
// The scans step word by word because the storage has a single read port and a single
// write port; sort uses a less-than comparator and dedupe an equality comparator.
// Reset empties the deque; the storage itself is not cleared and needs no pass.
`default_nettype none

module double_ended_queue_engine #(
	parameter int DEPTH = dqe_pkg::DEPTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic [dqe_pkg::KIND_W-1:0]         kind,
	input  wire logic signed [dqe_pkg::WORD_W-1:0]  value,
	output logic                                    done,
	output logic signed [dqe_pkg::WORD_W-1:0]       removed_value,
	output logic [dqe_pkg::COUNT_W-1:0]             count,
	output logic [dqe_pkg::STATUS_W-1:0]            status
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > dqe_pkg::COUNT_W) ? CW : dqe_pkg::COUNT_W;

	dqe_pkg::state_t  state_q, state_d;
	dqe_pkg::kind_t   kind_q, kind_d;
	dqe_pkg::status_t status_q, status_d;
	logic [IW-1:0]    head_q, head_d;
	logic [CW-1:0]    held_q, held_d;
	logic [CW-1:0]    i_q, i_d;
	logic [CW-1:0]    j_q, j_d;
	logic             swapped_q, swapped_d;
	logic             done_q, done_d;
	logic signed [dqe_pkg::WORD_W-1:0] carry_q, carry_d;
	logic signed [dqe_pkg::WORD_W-1:0] removed_q, removed_d;

	logic                              mem_we;
	logic [IW-1:0]                     mem_waddr;
	logic signed [dqe_pkg::WORD_W-1:0] mem_wdata;
	logic [IW-1:0]                     mem_raddr;
	logic signed [dqe_pkg::WORD_W-1:0] mem_rdata;

	logic [CW-1:0] slot_idx;
	logic [CW:0]   slot_sum;
	logic [CW:0]   slot_wrap;
	logic [IW-1:0] slot_addr;
	logic          cmp_lt;
	logic          cmp_eq;
	logic [CW-1:0] held_m1;
	logic          is_full;
	logic          is_empty;
	logic [XW-1:0] held_x;

	dqe_store #(
		.DEPTH(DEPTH),
		.AW   (IW)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Logical position to ring address.
	always_comb begin
		slot_sum  = (CW + 1)'(head_q) + (CW + 1)'(slot_idx);
		slot_wrap = (slot_sum >= (CW + 1)'(DEPTH)) ? slot_sum - (CW + 1)'(DEPTH) : slot_sum;
		slot_addr = slot_wrap[IW-1:0];
	end

	assign cmp_lt   = mem_rdata < carry_q;
	assign cmp_eq   = mem_rdata == carry_q;
	assign held_m1  = held_q - CW'(1);
	assign is_full  = held_q == CW'(DEPTH);
	assign is_empty = held_q == '0;

	always_comb begin
		state_d   = state_q;
		kind_d    = kind_q;
		status_d  = status_q;
		head_d    = head_q;
		held_d    = held_q;
		i_d       = i_q;
		j_d       = j_q;
		swapped_d = swapped_q;
		carry_d   = carry_q;
		removed_d = removed_q;
		done_d    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = slot_addr;
		mem_wdata = carry_q;
		slot_idx  = i_q;
		mem_raddr = slot_addr;

		case (state_q)
			dqe_pkg::ST_IDLE: begin
				if (start) begin
					kind_d    = dqe_pkg::kind_t'(kind);
					status_d  = dqe_pkg::STAT_OK;
					removed_d = '0;
					case (dqe_pkg::kind_t'(kind))
						dqe_pkg::KIND_PUT_FRONT: begin
							done_d = 1'b1;
							if (is_full) begin
								status_d = dqe_pkg::STAT_FULL;
							end else begin
								head_d    = (head_q == '0) ? IW'(DEPTH - 1) : head_q - IW'(1);
								mem_we    = 1'b1;
								mem_waddr = head_d;
								mem_wdata = value;
								held_d    = held_q + CW'(1);
							end
						end
						dqe_pkg::KIND_PUT_BACK: begin
							done_d   = 1'b1;
							slot_idx = held_q;
							if (is_full) begin
								status_d = dqe_pkg::STAT_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = slot_addr;
								mem_wdata = value;
								held_d    = held_q + CW'(1);
							end
						end
						dqe_pkg::KIND_TAKE_FRONT: begin
							if (is_empty) begin
								status_d = dqe_pkg::STAT_EMPTY;
								done_d   = 1'b1;
							end else begin
								mem_raddr = head_q;
								head_d    = (head_q == IW'(DEPTH - 1)) ? '0 : head_q + IW'(1);
								held_d    = held_m1;
								state_d   = dqe_pkg::ST_POP;
							end
						end
						dqe_pkg::KIND_TAKE_BACK: begin
							slot_idx = held_m1;
							if (is_empty) begin
								status_d = dqe_pkg::STAT_EMPTY;
								done_d   = 1'b1;
							end else begin
								mem_raddr = slot_addr;
								held_d    = held_m1;
								state_d   = dqe_pkg::ST_POP;
							end
						end
						dqe_pkg::KIND_CLEAR: begin
							held_d = '0;
							head_d = '0;
							done_d = 1'b1;
						end
						dqe_pkg::KIND_SORT, dqe_pkg::KIND_DEDUPE: begin
							if (held_q < CW'(2)) begin
								done_d = 1'b1;
							end else begin
								i_d       = '0;
								j_d       = CW'(1);
								swapped_d = 1'b0;
								state_d   = dqe_pkg::ST_SCAN_RD;
							end
						end
						dqe_pkg::KIND_REVERSE: begin
							if (held_q < CW'(2)) begin
								done_d = 1'b1;
							end else begin
								i_d     = '0;
								j_d     = held_m1;
								state_d = dqe_pkg::ST_REV_RA;
							end
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			dqe_pkg::ST_POP: begin
				removed_d = mem_rdata;
				done_d    = 1'b1;
				state_d   = dqe_pkg::ST_IDLE;
			end
			dqe_pkg::ST_SCAN_RD: begin
				slot_idx  = i_q;
				mem_raddr = slot_addr;
				state_d   = dqe_pkg::ST_SCAN_CMP;
			end
			dqe_pkg::ST_SCAN_CMP: begin
				if (i_q == '0) begin
					carry_d = mem_rdata;
					i_d     = CW'(1);
					state_d = dqe_pkg::ST_SCAN_RD;
				end else if (kind_q == dqe_pkg::KIND_SORT) begin
					// The larger word is carried forward; the smaller one settles behind it.
					slot_idx  = i_q - CW'(1);
					mem_we    = 1'b1;
					mem_waddr = slot_addr;
					if (cmp_lt) begin
						mem_wdata = mem_rdata;
						swapped_d = 1'b1;
					end else begin
						mem_wdata = carry_q;
						carry_d   = mem_rdata;
					end
					if (i_q == held_m1) begin
						state_d = dqe_pkg::ST_SORT_TAIL;
					end else begin
						i_d     = i_q + CW'(1);
						state_d = dqe_pkg::ST_SCAN_RD;
					end
				end else begin
					slot_idx = j_q;
					if (!cmp_eq) begin
						mem_we    = 1'b1;
						mem_waddr = slot_addr;
						mem_wdata = mem_rdata;
						j_d       = j_q + CW'(1);
						carry_d   = mem_rdata;
					end
					if (i_q == held_m1) begin
						held_d  = j_d;
						done_d  = 1'b1;
						state_d = dqe_pkg::ST_IDLE;
					end else begin
						i_d     = i_q + CW'(1);
						state_d = dqe_pkg::ST_SCAN_RD;
					end
				end
			end
			dqe_pkg::ST_SORT_TAIL: begin
				slot_idx  = held_m1;
				mem_we    = 1'b1;
				mem_waddr = slot_addr;
				mem_wdata = carry_q;
				if (swapped_q) begin
					i_d       = '0;
					swapped_d = 1'b0;
					state_d   = dqe_pkg::ST_SCAN_RD;
				end else begin
					done_d  = 1'b1;
					state_d = dqe_pkg::ST_IDLE;
				end
			end
			dqe_pkg::ST_REV_RA: begin
				slot_idx  = i_q;
				mem_raddr = slot_addr;
				state_d   = dqe_pkg::ST_REV_RB;
			end
			dqe_pkg::ST_REV_RB: begin
				carry_d   = mem_rdata;
				slot_idx  = j_q;
				mem_raddr = slot_addr;
				state_d   = dqe_pkg::ST_REV_W1;
			end
			dqe_pkg::ST_REV_W1: begin
				slot_idx  = i_q;
				mem_we    = 1'b1;
				mem_waddr = slot_addr;
				mem_wdata = mem_rdata;
				state_d   = dqe_pkg::ST_REV_W2;
			end
			dqe_pkg::ST_REV_W2: begin
				slot_idx  = j_q;
				mem_we    = 1'b1;
				mem_waddr = slot_addr;
				mem_wdata = carry_q;
				if ((CW + 1)'(i_q) + (CW + 1)'(2) < (CW + 1)'(j_q)) begin
					i_d     = i_q + CW'(1);
					j_d     = j_q - CW'(1);
					state_d = dqe_pkg::ST_REV_RA;
				end else begin
					done_d  = 1'b1;
					state_d = dqe_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dqe_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= dqe_pkg::ST_IDLE;
			head_q    <= '0;
			held_q    <= '0;
			done_q    <= 1'b0;
			swapped_q <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
			kind_q    <= dqe_pkg::KIND_PUT_FRONT;
			status_q  <= dqe_pkg::STAT_OK;
		end else begin
			state_q   <= state_d;
			head_q    <= head_d;
			held_q    <= held_d;
			done_q    <= done_d;
			swapped_q <= swapped_d;
			i_q       <= i_d;
			j_q       <= j_d;
			kind_q    <= kind_d;
			status_q  <= status_d;
		end
	end

	always_ff @(posedge clk) begin
		carry_q   <= carry_d;
		removed_q <= removed_d;
	end

	assign held_x        = XW'(held_q);
	assign busy          = state_q != dqe_pkg::ST_IDLE;
	assign done          = done_q;
	assign removed_value = removed_q;
	assign count         = held_x[dqe_pkg::COUNT_W-1:0];
	assign status        = status_q;

`ifndef SYNTHESIS
	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CW'(DEPTH))
		else $error("deque holds more words than its depth");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == dqe_pkg::ST_IDLE)
		else $error("result shown while a request is still in work");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && status_q == dqe_pkg::STAT_FULL |-> is_full)
		else $error("push refused although the deque is not full");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && status_q == dqe_pkg::STAT_EMPTY |-> is_empty)
		else $error("pop refused although the deque holds words");

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == dqe_pkg::ST_IDLE && start) || state_q == dqe_pkg::ST_SCAN_CMP
			|| state_q == dqe_pkg::ST_SORT_TAIL || state_q == dqe_pkg::ST_REV_W1
			|| state_q == dqe_pkg::ST_REV_W2)
		else $error("storage written outside a writing step");

	a_pop_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dqe_pkg::ST_POP |=> done_q && status_q == dqe_pkg::STAT_OK)
		else $error("pop did not deliver its item");
`endif

endmodule

`default_nettype wire
